[sv/ltm_pkg.sv]
// Package for the linear-to-Morton index converter: widths, register
// indexes and the record type that travels down the divider cell chain.
// No dependencies.
package ltm_pkg;

  localparam int MAX_DIMS   = 4;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = 64;
  localparam int SIDE_W     = 17;
  localparam int DIMS_W     = 3;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 1;
  // One cell per quotient bit, one full division per dimension.
  localparam int CELLS      = MAX_DIMS * IDX_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIDE_LENGTH = 1'b0,
    CFG_DIMENSIONS  = 1'b1
  } cfg_idx_t;

  typedef logic [MAX_DIMS-1:0][COORD_BITS-1:0] coord_arr_t;

  typedef struct packed {
    logic              valid;
    logic [SIDE_W-1:0] rem;
    logic [IDX_W-1:0]  word;
    coord_arr_t        coords;
  } cell_t;

endpackage

[sv/ltm_in_if.sv]
// Input channel of the converter: valid/ready plus the linear index.
// Depends on ltm_pkg.
interface ltm_in_if;
  import ltm_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] linear_index;
  modport source (output valid, output linear_index, input ready);
  modport sink (input valid, input linear_index, output ready);
endinterface

[sv/ltm_out_if.sv]
// Result channel of the converter: valid/ready plus the Morton index.
// Depends on ltm_pkg.
interface ltm_out_if;
  import ltm_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] morton_index;
  modport source (output valid, output morton_index, input ready);
  modport sink (input valid, input morton_index, output ready);
endinterface

[sv/ltm_div_cell.sv]
// One restoring-division step: shifts one dividend bit into the partial
// remainder and one quotient bit into the word. Depends on ltm_pkg.
module ltm_div_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic [ltm_pkg::SIDE_W-1:0] side,
  input  ltm_pkg::cell_t        d_in,
  output ltm_pkg::cell_t        d_out
);
  import ltm_pkg::*;

  logic [SIDE_W:0]   trial;
  logic [SIDE_W:0]   diff;
  logic              ge;
  logic              valid_r;
  logic [SIDE_W-1:0] rem_r, rem_nxt;
  logic [IDX_W-1:0]  word_r, word_nxt;
  coord_arr_t        coords_r;

  always_comb begin
    trial    = {d_in.rem, d_in.word[IDX_W-1]};
    diff     = trial - {1'b0, side};
    ge       = (trial >= {1'b0, side});
    // With a zero divisor the remainder is garbage; the output stage
    // forces every coordinate to zero in that case.
    rem_nxt  = ge ? diff[SIDE_W-1:0] : trial[SIDE_W-1:0];
    word_nxt = {d_in.word[IDX_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= d_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r    <= rem_nxt;
      word_r   <= word_nxt;
      coords_r <= d_in.coords;
    end
  end

  assign d_out = '{valid: valid_r, rem: rem_r, word: word_r, coords: coords_r};

endmodule

[sv/ltm_out_stage.sv]
// Output register: interleaves the collected coordinates into the
// Morton index and adds the base offset. Depends on ltm_pkg.
module ltm_out_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [ltm_pkg::SIDE_W-1:0] side,
  input  logic [ltm_pkg::DIMS_W-1:0] dims,
  input  ltm_pkg::cell_t             d_in,
  output logic                       valid,
  output logic [ltm_pkg::IDX_W-1:0]  morton
);
  import ltm_pkg::*;

  logic [IDX_W-1:0] ilv;
  logic [IDX_W-1:0] morton_r;
  logic             valid_r;
  coord_arr_t       c;

  // Coordinates arrive in remainder order: slot j is coordinate dims-1-j,
  // which is exactly the one that lands at bit offset j.
  always_comb begin
    c   = (side == '0) ? '0 : d_in.coords;
    ilv = '0;
    unique case (dims)
      3'd0: ilv = '0;
      3'd1: begin
        for (int i = 0; i < COORD_BITS; i++) ilv[i] = c[0][i];
      end
      3'd2: begin
        for (int i = 0; i < COORD_BITS; i++)
          for (int j = 0; j < 2; j++) ilv[i*2+j] = c[j][i];
      end
      3'd3: begin
        for (int i = 0; i < COORD_BITS; i++)
          for (int j = 0; j < 3; j++) ilv[i*3+j] = c[j][i];
      end
      default: begin
        for (int i = 0; i < COORD_BITS; i++)
          for (int j = 0; j < MAX_DIMS; j++) ilv[i*MAX_DIMS+j] = c[j][i];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= d_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      morton_r <= ilv + IDX_W'(1);
    end
  end

  assign valid  = valid_r;
  assign morton = morton_r;

endmodule

[sv/linear_to_morton_index.sv]
// Top level of the linear-to-Morton index converter: configuration
// registers, the chain of divider cells and the output stage.
// Depends on ltm_pkg, ltm_in_if, ltm_out_if, ltm_div_cell, ltm_out_stage.
//
//   channel  | direction | payload                  | handshake
//   in_ch    | in        | linear_index  [63:0]     | valid / ready
//   out_ch   | out       | morton_index  [63:0]     | valid / ready
//   cfg_*    | in        | cfg_index, cfg_data[16:0]| cfg_we, no wait
//
// One transaction is accepted per cycle unless stalled; each passes
// through 256 one-bit restoring-division cells (four 64-bit divisions
// by N) and the output register; the whole chain advances together and
// stalls only while a finished result waits there with out_ch.ready low.
// Synchronous reset clears the valid bits and sets N to 16, dims to 2.
module linear_to_morton_index (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ltm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ltm_pkg::CFG_DATA_W-1:0] cfg_data,
  ltm_in_if.sink                        in_ch,
  ltm_out_if.source                     out_ch
);
  import ltm_pkg::*;

  logic [SIDE_W-1:0] side_r;
  logic [DIMS_W-1:0] dims_r;
  logic              en;
  logic              out_valid;
  cell_t             cin  [CELLS];
  cell_t             cout [CELLS];
  cell_t             fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_W'(16);
      dims_r <= DIMS_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SIDE_LENGTH: side_r <= cfg_data[SIDE_W-1:0];
        CFG_DIMENSIONS:  dims_r <= cfg_data[DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  assign en          = !out_valid || out_ch.ready;
  assign in_ch.ready = en;

  assign cin[0] = '{valid: in_ch.valid, rem: '0, word: in_ch.linear_index,
                    coords: '0};

  for (genvar s = 0; s < CELLS; s++) begin : g_cell
    if (s > 0) begin : g_link
      if ((s % IDX_W) == 0) begin : g_bound
        localparam int SLOT = s / IDX_W - 1;
        // End of one division: bank the remainder, divide the quotient.
        always_comb begin
          cin[s]              = cout[s-1];
          cin[s].rem          = '0;
          cin[s].coords[SLOT] = cout[s-1].rem[COORD_BITS-1:0];
        end
      end else begin : g_pass
        assign cin[s] = cout[s-1];
      end
    end
    ltm_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .side  (side_r),
      .d_in  (cin[s]),
      .d_out (cout[s])
    );
  end

  always_comb begin
    fin                        = cout[CELLS-1];
    fin.coords[MAX_DIMS-1]     = cout[CELLS-1].rem[COORD_BITS-1:0];
  end

  ltm_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .side   (side_r),
    .dims   ((dims_r > DIMS_W'(MAX_DIMS)) ? DIMS_W'(MAX_DIMS) : dims_r),
    .d_in   (fin),
    .valid  (out_valid),
    .morton (out_ch.morton_index)
  );

  assign out_ch.valid = out_valid;

endmodule

[sim/tb_top.sv]
// Testbench for linear_to_morton_index: streams linear indexes through
// several side/dimension settings and checks every Morton index returned.
// Depends on ltm_pkg, ltm_in_if, ltm_out_if and the converter itself.
`timescale 1ns / 100ps

module tb_top;
  import ltm_pkg::*;

  class morton_scoreboard;
    logic [SIDE_W-1:0] side;
    logic [DIMS_W-1:0] dims;
    logic [IDX_W-1:0] morton_q[$];
    int mismatches;
    int checked;

    function new();
      side = 17'd16;
      dims = 3'd2;
      mismatches = 0;
      checked = 0;
    endfunction

    function logic [IDX_W-1:0] morton_of(logic [IDX_W-1:0] lin);
      logic [IDX_W-1:0] stride;
      logic [IDX_W-1:0] morton;
      logic [COORD_BITS-1:0] coords[MAX_DIMS];
      int nd;
      int pos;
      nd = (dims > MAX_DIMS) ? MAX_DIMS : int'(dims);
      morton = '0;
      for (int k = 0; k < nd; k++) begin
        if (side == 0) begin
          coords[k] = '0;
        end else begin
          stride = 64'd1;
          for (int m = k + 1; m < nd; m++) stride = stride * side;
          coords[k] = COORD_BITS'((lin / stride) % side);
        end
      end
      for (int i = 0; i < COORD_BITS; i++) begin
        for (int j = 0; j < nd; j++) begin
          pos = i * nd + j;
          if (pos < IDX_W) morton[pos] = coords[nd - 1 - j][i];
        end
      end
      return morton + 64'd1;
    endfunction

    function void note_index(logic [IDX_W-1:0] lin);
      morton_q.push_back(morton_of(lin));
    endfunction

    function void check_morton(logic [IDX_W-1:0] got);
      logic [IDX_W-1:0] want;
      if (morton_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: %h", got);
        return;
      end
      want = morton_q.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("morton_index mismatch: expected %h, got %h", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SIDE_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ltm_in_if in_ch ();
  ltm_out_if out_ch ();

  linear_to_morton_index dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #1 clk = ~clk;

  morton_scoreboard sb = new();
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int quiet_cycles = 0;
  int sent = 0;
  int settings_used = 0;
  localparam int QUIET_LIMIT = 5000;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.linear_index = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= out_idle_pct);

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_index(in_ch.linear_index);
      if (out_ch.valid && out_ch.ready) sb.check_morton(out_ch.morton_index);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog expired after %0d idle cycles", QUIET_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_index(logic [IDX_W-1:0] lin);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.linear_index = lin;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  // Called only with the converter drained, so no transaction in flight
  // sees a half-updated setting.
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_SIDE_LENGTH) sb.side = val;
    else sb.dims = val[DIMS_W-1:0];
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (sb.morton_q.size() != 0) @(negedge clk);
    repeat (270) @(negedge clk);
  endtask

  function automatic logic [IDX_W-1:0] random_index();
    logic [IDX_W-1:0] v;
    logic [IDX_W-1:0] span;
    v = {$urandom, $urandom};
    case ($urandom_range(3))
      0, 1: begin
        // Half of the draws stay inside the cube so the coordinates are meaningful.
        span = 64'd1;
        for (int k = 0; k < sb.dims && k < MAX_DIMS; k++) span = span * sb.side;
        if (span != 0) v = v % span;
      end
      2: v = v >> $urandom_range(63);
      default: ;
    endcase
    return v;
  endfunction

  task automatic run_setting(logic [CFG_DATA_W-1:0] side, logic [CFG_DATA_W-1:0] nd,
                             int n_random);
    write_reg(CFG_SIDE_LENGTH, side);
    write_reg(CFG_DIMENSIONS, nd);
    settings_used++;
    send_index(64'd0);
    send_index(64'd1);
    send_index({IDX_W{1'b1}});
    send_index(64'h8000_0000_0000_0000);
    send_index(64'(side) - 64'd1);
    for (int i = 0; i < n_random; i++) send_index(random_index());
    drain();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    in_idle_pct = 19;
    out_idle_pct = 55;

    // Reset setting first, without touching the registers.
    send_index(64'd0);
    send_index(64'd255);
    send_index(64'd17);
    for (int i = 0; i < 40; i++) send_index(random_index());
    drain();

    run_setting(17'd65536, 17'd4, 40);
    run_setting(17'd1, 17'd1, 30);
    run_setting(17'd0, 17'd3, 20);
    run_setting(17'd3, 17'd0, 20);
    in_idle_pct = 55;
    out_idle_pct = 19;
    run_setting(17'd5, 17'd7, 40);
    run_setting(17'h1FFFF, 17'd4, 40);
    run_setting(17'd2, 17'd4, 50);
    run_setting(17'd65535, 17'd2, 40);
    in_idle_pct = 0;
    out_idle_pct = 0;
    run_setting(17'd255, 17'd3, 60);
    run_setting(17'd7, 17'd1, 40);
    run_setting(17'd100000, 17'd3, 50);
    run_setting(17'd1000, 17'd4, 60);
    run_setting(17'd16, 17'd2, 40);

    $display("Covered %0d index transactions over %0d register settings, %0d results checked.",
             sent, settings_used + 1, sb.checked);
    $display("Settings spanned side lengths 0 to 131071 and dimension counts 0 to 7.");
    if (sb.mismatches == 0 && sb.morton_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.morton_q.size());
      $display("FAILURE");
    end
    $finish;
  end
endmodule
